// ----- rtl/core/fpl_pkg.sv -----
package fpl_pkg;

  // fader count and derived widths
  localparam int FADER_COUNT = 8;
  localparam int FADER_AW    = (FADER_COUNT > 1) ? $clog2(FADER_COUNT) : 1;

  // field widths fixed by the transaction format
  localparam int FADER_W = 3;
  localparam int POINT_W = 2;
  localparam int POS_W   = 12;
  localparam int OUT_W   = 10;

  // point slots within one fader's row
  localparam logic [POINT_W-1:0] PT_HALF = 2'd0;
  localparam logic [POINT_W-1:0] PT_QTR  = 2'd1;
  localparam logic [POINT_W-1:0] PT_3QTR = 2'd2;
  localparam logic [POINT_W-1:0] PT_FULL = 2'd3;
  localparam int POINT_COUNT = 4;

  // operation codes
  localparam logic OP_MAP   = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // reset values of the points, by slot
  localparam logic [POS_W-1:0] PT_RESET [POINT_COUNT] = '{
    12'd2048, 12'd1024, 12'd3072, 12'd4095
  };

  // fixed results
  localparam logic [OUT_W-1:0] OUT_ZERO = 10'd0;
  localparam logic [OUT_W-1:0] OUT_QTR  = 10'd256;
  localparam logic [OUT_W-1:0] OUT_HALF = 10'd512;
  localparam logic [OUT_W-1:0] OUT_3QTR = 10'd768;
  localparam logic [OUT_W-1:0] OUT_MAX  = 10'h3FF;

  // divider pipeline shape: OUT_W quotient bits, BITS_PER_STAGE per stage
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = OUT_W / BITS_PER_STAGE;

  // one map transaction as it travels through the divider
  typedef struct packed {
    logic [POS_W-1:0]   rem;        // partial remainder, below den on the divide path
    logic [POS_W-1:0]   den;        // segment width hi - lo
    logic [OUT_W-1:0]   quo;        // quotient bits so far
    logic [POINT_W-1:0] seg;        // segment number, upper bits of the sum
    logic               fixed;      // result known without division
    logic [OUT_W-1:0]   fixed_val;
  } div_tok_t;

endpackage

// ----- rtl/core/fader_piecewise_linear_calibration.sv -----
// a map transaction accepted at one clock edge passes stage 0, stage 1, the divider
//   stages and the output register before its result is on the out_ ports (out_valid one cycle)
// throughput: one transaction per cycle, busy stays low; writes give no result
// the calibration row is read in the accept cycle, so a write is seen by the next map
// reset (rst_n low, synchronous) loads the default points and empties the pipeline
module fader_piecewise_linear_calibration (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_operation,
  input  logic [fpl_pkg::FADER_W-1:0] in_fader_index,
  input  logic [fpl_pkg::POINT_W-1:0] in_point_index,
  input  logic [fpl_pkg::POS_W-1:0]   in_raw_position,
  input  logic [fpl_pkg::POS_W-1:0]   in_point_value,
  output logic                        out_valid,
  output logic [fpl_pkg::OUT_W-1:0]   out_calibrated_position
);
  import fpl_pkg::*;

  // ---------------------------------------------------------------
  // calibration points, one row of four per fader
  // ---------------------------------------------------------------
  logic [POS_W-1:0]    tbl_r [FADER_COUNT][POINT_COUNT];
  logic                accept;
  logic                fader_ok;
  logic [FADER_AW-1:0] row_idx;

  // the pipeline never holds off a transaction
  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign fader_ok = 7'(in_fader_index) < 7'(FADER_COUNT);
  assign row_idx  = in_fader_index[FADER_AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int f = 0; f < FADER_COUNT; f++) begin
        for (int p = 0; p < POINT_COUNT; p++) begin
          tbl_r[f][p] <= PT_RESET[p];
        end
      end
    end else if (accept && in_operation == OP_WRITE && fader_ok) begin
      tbl_r[row_idx][in_point_index] <= in_point_value;
    end
  end

  // ---------------------------------------------------------------
  // stage 0: capture the position and the fader's row
  // ---------------------------------------------------------------
  logic             s0_vld_r;
  logic             s0_ok_r;
  logic [POS_W-1:0] s0_pos_r;
  logic [POS_W-1:0] s0_pts_r [POINT_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= accept && in_operation == OP_MAP;
    end
  end

  always_ff @(posedge clk) begin
    s0_ok_r  <= fader_ok;
    s0_pos_r <= in_raw_position;
    for (int p = 0; p < POINT_COUNT; p++) begin
      s0_pts_r[p] <= tbl_r[row_idx][p];
    end
  end

  // ---------------------------------------------------------------
  // stage 1: segment search, special cases, numerator and divisor
  // segments are tested in order quarter, half, three-quarter, full
  // ---------------------------------------------------------------
  logic             s1_vld_r;
  div_tok_t         s1_tok_r;
  div_tok_t         s1_tok_nxt;
  logic [POS_W-1:0] pq, ph, pt, pf, lo, hi;

  always_comb begin
    pq = s0_pts_r[PT_QTR];
    ph = s0_pts_r[PT_HALF];
    pt = s0_pts_r[PT_3QTR];
    pf = s0_pts_r[PT_FULL];
    lo = '0;
    hi = pq;
    s1_tok_nxt.seg       = 2'd0;
    s1_tok_nxt.fixed     = 1'b0;
    s1_tok_nxt.fixed_val = OUT_ZERO;
    if (!s0_ok_r || s0_pos_r == '0) begin
      s1_tok_nxt.fixed = 1'b1;
    end else if (s0_pos_r < pq) begin
      lo = '0;
      hi = pq;
    end else if (s0_pos_r == pq) begin
      s1_tok_nxt.fixed     = 1'b1;
      s1_tok_nxt.fixed_val = OUT_QTR;
    end else if (s0_pos_r < ph) begin
      lo = pq;
      hi = ph;
      s1_tok_nxt.seg = 2'd1;
    end else if (s0_pos_r == ph) begin
      s1_tok_nxt.fixed     = 1'b1;
      s1_tok_nxt.fixed_val = OUT_HALF;
    end else if (s0_pos_r < pt) begin
      lo = ph;
      hi = pt;
      s1_tok_nxt.seg = 2'd2;
    end else if (s0_pos_r == pt) begin
      s1_tok_nxt.fixed     = 1'b1;
      s1_tok_nxt.fixed_val = OUT_3QTR;
    end else if (s0_pos_r < pf) begin
      lo = pt;
      hi = pf;
      s1_tok_nxt.seg = 2'd3;
    end else begin
      // at or above full scale
      s1_tok_nxt.fixed     = 1'b1;
      s1_tok_nxt.fixed_val = OUT_MAX;
    end
    // lo < pos < hi on the divide path, so rem starts below den
    s1_tok_nxt.rem = s0_pos_r - lo;
    s1_tok_nxt.den = hi - lo;
    s1_tok_nxt.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_tok_r <= s1_tok_nxt;
  end

  // ---------------------------------------------------------------
  // pipelined divider: quotient (pos - lo) * 1024 / (hi - lo)
  // ---------------------------------------------------------------
  logic     dv_vld;
  div_tok_t dv_tok;

  fpl_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s1_vld_r),
    .in_tok  (s1_tok_r),
    .out_vld (dv_vld),
    .out_tok (dv_tok)
  );

  // ---------------------------------------------------------------
  // output stage: add segment base, round half up to 10 bits, saturate
  // ---------------------------------------------------------------
  logic [POS_W-1:0] sum12;
  logic [POS_W:0]   rnd;
  logic [OUT_W-1:0] cal_nxt;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_cal_r;

  always_comb begin
    // base is seg * 1024, so the sum is a plain concatenation
    sum12 = {dv_tok.seg, dv_tok.quo};
    rnd   = {1'b0, sum12} + {10'd0, sum12[1], 2'b00};
    if (dv_tok.fixed) begin
      cal_nxt = dv_tok.fixed_val;
    end else if (rnd[POS_W]) begin
      cal_nxt = OUT_MAX;
    end else begin
      cal_nxt = rnd[POS_W-1:2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_cal_r <= cal_nxt;
  end

  assign out_valid               = out_valid_r;
  assign out_calibrated_position = out_cal_r;

`ifndef SYNTHESIS
  // every accepted map transaction gives a result on the out_ ports
  a_map_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == OP_MAP) |-> ##8 out_valid)
    else $error("map transaction produced no result");

  // no result without an earlier map transaction
  a_result_has_map: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(rst_n && accept && in_operation == OP_MAP, 8))
    else $error("result without a map transaction");

  // an accepted write lands in the addressed point
  a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == OP_WRITE && fader_ok) |=>
      (tbl_r[$past(row_idx)][$past(in_point_index)] == $past(in_point_value)))
    else $error("calibration write lost");
`endif

endmodule

// ----- rtl/core/fpl_divider.sv -----
module fpl_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  fpl_pkg::div_tok_t  in_tok,
  output logic               out_vld,
  output fpl_pkg::div_tok_t  out_tok
);
  import fpl_pkg::*;

  logic     vld_r [DIV_STAGES];
  div_tok_t tok_r [DIV_STAGES];
  div_tok_t tok_nxt [DIV_STAGES];

  // restoring division, BITS_PER_STAGE quotient bits per stage
  function automatic div_tok_t div_step(input div_tok_t t);
    div_tok_t           o;
    logic [POS_W:0]     r2;
    o = t;
    for (int b = 0; b < BITS_PER_STAGE; b++) begin
      r2 = {o.rem, 1'b0};
      if (r2 >= {1'b0, o.den}) begin
        r2 = r2 - {1'b0, o.den};
        o.quo = {o.quo[OUT_W-2:0], 1'b1};
      end else begin
        o.quo = {o.quo[OUT_W-2:0], 1'b0};
      end
      o.rem = r2[POS_W-1:0];
    end
    return o;
  endfunction

  always_comb begin
    tok_nxt[0] = div_step(in_tok);
    for (int s = 1; s < DIV_STAGES; s++) begin
      tok_nxt[s] = div_step(tok_r[s-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      vld_r[0] <= in_vld;
      for (int s = 1; s < DIV_STAGES; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      tok_r[s] <= tok_nxt[s];
    end
  end

  assign out_vld = vld_r[DIV_STAGES-1];
  assign out_tok = tok_r[DIV_STAGES-1];

`ifndef SYNTHESIS
  // remainder stays below the divisor for every real division
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld && !out_tok.fixed) |-> (out_tok.rem < out_tok.den))
    else $error("divider remainder not below divisor");
`endif

endmodule
